// File: rtl/spfd_pkg.sv
// ---------------------------------------------------------------------------
// spfd_pkg - shared types and constants for the sync prefix frame deframer
// Holds the parser phase encoding, the result item layout and the widths
// used by the parser core and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package spfd_pkg;

    // Number of consecutive sync bytes that open a frame (1 to 16)
    localparam int unsigned PREFIX_LEN = 4;

    // Run counter only has to reach PREFIX_LEN
    localparam int unsigned SYNC_RUN_W = $clog2(PREFIX_LEN + 1);

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned COUNT_W = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST = 8'hAA;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]  payload_byte;
        logic               frame_end;
        logic               checksum_ok;
        logic [COUNT_W-1:0] good_frame_count;
    } t_result;

endpackage : spfd_pkg

`default_nettype wire

// File: rtl/spfd_core.sv
// ---------------------------------------------------------------------------
// spfd_core - frame parser state machine
// Consumes one byte per step: hunts the sync prefix, reads the big-endian
// length, passes payload bytes and checks the XOR checksum at frame end.
// The result for a step is combinational from the current state and byte.
// ---------------------------------------------------------------------------
`default_nettype none

module spfd_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_step,
    input  wire logic [spfd_pkg::BYTE_W-1:0]     i_byte,
    input  wire logic [spfd_pkg::BYTE_W-1:0]     i_sync_byte,
    output logic                                 o_res_valid,
    output spfd_pkg::t_result                    o_res
);

    spfd_pkg::t_phase                    r_phase, n_phase;
    logic [spfd_pkg::SYNC_RUN_W-1:0]     r_sync_run, n_sync_run;
    logic [spfd_pkg::BYTE_W-1:0]         r_length_high, n_length_high;
    logic [spfd_pkg::LEN_W-1:0]          r_bytes_left, n_bytes_left;
    logic [spfd_pkg::BYTE_W-1:0]         r_xor_acc, n_xor_acc;
    logic [spfd_pkg::COUNT_W-1:0]        r_good_frames, n_good_frames;

    logic [spfd_pkg::SYNC_RUN_W-1:0]     run_inc;
    logic [spfd_pkg::LEN_W-1:0]          length;
    logic                                ok;

    assign run_inc = r_sync_run + spfd_pkg::SYNC_RUN_W'(1);
    assign length  = {r_length_high, i_byte};
    assign ok      = (r_xor_acc == i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= spfd_pkg::PH_HUNT;
            r_sync_run    <= '0;
            r_length_high <= '0;
            r_bytes_left  <= '0;
            r_xor_acc     <= '0;
            r_good_frames <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_sync_run    <= n_sync_run;
            r_length_high <= n_length_high;
            r_bytes_left  <= n_bytes_left;
            r_xor_acc     <= n_xor_acc;
            r_good_frames <= n_good_frames;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_sync_run    = r_sync_run;
        n_length_high = r_length_high;
        n_bytes_left  = r_bytes_left;
        n_xor_acc     = r_xor_acc;
        n_good_frames = r_good_frames;
        o_res_valid   = 1'b0;
        o_res.payload_byte     = '0;
        o_res.frame_end        = 1'b0;
        o_res.checksum_ok      = 1'b0;
        o_res.good_frame_count = r_good_frames;

        case (r_phase)
            spfd_pkg::PH_HUNT: begin
                if (i_byte == i_sync_byte) begin
                    // run never exceeds PREFIX_LEN, so no saturation needed
                    if (run_inc == spfd_pkg::SYNC_RUN_W'(spfd_pkg::PREFIX_LEN)) begin
                        n_phase    = spfd_pkg::PH_LEN_HI;
                        n_sync_run = '0;
                    end else begin
                        n_sync_run = run_inc;
                    end
                end else begin
                    n_sync_run = '0;
                end
            end
            spfd_pkg::PH_LEN_HI: begin
                n_length_high = i_byte;
                n_phase       = spfd_pkg::PH_LEN_LO;
            end
            spfd_pkg::PH_LEN_LO: begin
                n_xor_acc = '0;
                if (length == '0) begin
                    // drop empty frame
                    n_phase      = spfd_pkg::PH_HUNT;
                    n_sync_run   = '0;
                    n_bytes_left = '0;
                end else begin
                    n_bytes_left = length;
                    n_phase      = spfd_pkg::PH_BODY;
                end
            end
            spfd_pkg::PH_BODY: begin
                o_res_valid = 1'b1;
                if (r_bytes_left > spfd_pkg::LEN_W'(1)) begin
                    n_xor_acc          = r_xor_acc ^ i_byte;
                    n_bytes_left       = r_bytes_left - spfd_pkg::LEN_W'(1);
                    o_res.payload_byte = i_byte;
                end else begin
                    if (ok) begin
                        n_good_frames = r_good_frames + spfd_pkg::COUNT_W'(1);
                    end
                    o_res.frame_end        = 1'b1;
                    o_res.checksum_ok      = ok;
                    o_res.good_frame_count = n_good_frames;
                    n_phase      = spfd_pkg::PH_HUNT;
                    n_sync_run   = '0;
                    n_bytes_left = '0;
                    n_xor_acc    = '0;
                end
            end
            default: begin
                n_phase = spfd_pkg::PH_HUNT;
            end
        endcase
    end

endmodule : spfd_core

`default_nettype wire

// File: rtl/sync_prefix_frame_deframer.sv
// ---------------------------------------------------------------------------
// sync_prefix_frame_deframer - sync-word framed byte stream deframer
// Cuts a received byte stream into length-prefixed frames with XOR checksum.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / i_rx_byte, held off by o_stall. One received
//   byte per item. Output channel: o_valid with o_payload_byte, o_frame_end,
//   o_checksum_ok and o_good_frame_count, held off by i_stall.
//   A frame is PREFIX_LEN sync bytes, a 16-bit big-endian length L, L-1
//   payload bytes and one checksum byte. Each payload byte yields one item;
//   the checksum byte yields an end item with the pass flag and the running
//   good-frame count. Prefix, length bytes and empty frames yield nothing.
//   i_cfg_wr_en / i_cfg_wr_data set the sync byte (0xAA after reset); write
//   it only while the block is idle.
// Timing:
//   An accepted item waits in the input register and is parsed from there;
//   its result, if any, is loaded into the result register, which drives
//   the output. Throughput is one item per cycle while the output is not
//   stalled, set by the combinational parser step between the two registers.
// Reset and stall:
//   Reset empties both registers, returns the parser to prefix hunt and
//   clears the good-frame count. While i_stall holds a result, the input
//   register fills once and then o_stall rises; nothing is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_prefix_frame_deframer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [spfd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [spfd_pkg::BYTE_W-1:0]          o_payload_byte,
    output logic                                 o_frame_end,
    output logic                                 o_checksum_ok,
    output logic [spfd_pkg::COUNT_W-1:0]         o_good_frame_count,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [spfd_pkg::BYTE_W-1:0]     i_cfg_wr_data
);

    logic                            r_sync_byte_vld;
    logic [spfd_pkg::BYTE_W-1:0]     r_sync_byte;
    logic                            r_in_valid;
    logic [spfd_pkg::BYTE_W-1:0]     r_in_byte;
    logic                            r_out_valid;
    spfd_pkg::t_result               r_out;

    logic                            out_free;
    logic                            step;
    logic                            res_valid;
    spfd_pkg::t_result               res;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // Sync byte register; r_sync_byte_vld marks it written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte_vld <= 1'b0;
            r_sync_byte     <= spfd_pkg::SYNC_BYTE_RST;
        end else if (i_cfg_wr_en) begin
            r_sync_byte_vld <= 1'b1;
            r_sync_byte     <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    spfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_sync_byte (r_sync_byte_vld ? r_sync_byte : spfd_pkg::SYNC_BYTE_RST),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register: load when empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_payload_byte     = r_out.payload_byte;
    assign o_frame_end        = r_out.frame_end;
    assign o_checksum_ok      = r_out.checksum_ok;
    assign o_good_frame_count = r_out.good_frame_count;

endmodule : sync_prefix_frame_deframer

`default_nettype wire

// File: rtl/spfd_checker.sv
// ---------------------------------------------------------------------------
// spfd_checker - port-level checks for the sync prefix frame deframer
// Watches the output channel for held items, item field rules and a consistent frame count.
// ---------------------------------------------------------------------------
`default_nettype none

module spfd_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_valid,
    input  wire logic                            i_stall,
    input  wire logic [spfd_pkg::BYTE_W-1:0]     o_payload_byte,
    input  wire logic                            o_frame_end,
    input  wire logic                            o_checksum_ok,
    input  wire logic [spfd_pkg::COUNT_W-1:0]    o_good_frame_count
);

    logic                            r_seen;
    logic [spfd_pkg::COUNT_W-1:0]    r_last_cnt;
    logic                            out_take;

    assign out_take = o_valid && !i_stall;

    // Track the count of the last item taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_cnt <= '0;
        end else if (out_take) begin
            r_seen     <= 1'b1;
            r_last_cnt <= o_good_frame_count;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
            && $stable(o_frame_end) && $stable(o_good_frame_count))
        else $error("stalled output item changed");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_payload_byte == '0)
        else $error("end item carries a payload byte");

    a_pay_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |-> !o_checksum_ok)
        else $error("payload item flags checksum pass");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_seen |->
            (o_frame_end && o_checksum_ok
                && o_good_frame_count == r_last_cnt + spfd_pkg::COUNT_W'(1))
            || (!(o_frame_end && o_checksum_ok) && o_good_frame_count == r_last_cnt))
        else $error("good frame count stepped wrongly");

endmodule : spfd_checker

bind sync_prefix_frame_deframer spfd_checker u_spfd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_payload_byte     (o_payload_byte),
    .o_frame_end        (o_frame_end),
    .o_checksum_ok      (o_checksum_ok),
    .o_good_frame_count (o_good_frame_count)
);

`default_nettype wire

// File: test/deframer_checker.sv
// ---------------------------------------------------------------------------
// deframer_checker - prediction and result check for the frame deframer
// Watches the byte input, the result output and the sync byte register
// write. Runs its own deframing state machine on every accepted byte, queues
// the payload and end items that the bytes should produce, and compares each
// accepted result item, field by field, against the oldest queued one.
// ---------------------------------------------------------------------------

module deframer_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_stall,
    input  wire logic [spfd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic [spfd_pkg::BYTE_W-1:0]  i_payload_byte,
    input  wire logic                         i_frame_end,
    input  wire logic                         i_checksum_ok,
    input  wire logic [spfd_pkg::COUNT_W-1:0] i_good_frame_count,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [spfd_pkg::BYTE_W-1:0]  i_cfg_wr_data,
    output int                                o_mismatches,
    output int                                o_pending
);

    localparam int MAX_PRINTED = 40;

    // Deframer state mirrored from the block
    logic [spfd_pkg::BYTE_W-1:0]  sync_value;
    spfd_pkg::t_phase             phase;
    logic [4:0]                   sync_run;
    logic [spfd_pkg::BYTE_W-1:0]  len_high;
    logic [spfd_pkg::LEN_W-1:0]   bytes_left;
    logic [spfd_pkg::BYTE_W-1:0]  xor_acc;
    logic [spfd_pkg::COUNT_W-1:0] good_frames;

    spfd_pkg::t_result frame_items_due[$];
    spfd_pkg::t_result predicted;
    spfd_pkg::t_result oldest;
    bit      produced;
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic restart_hunt();
        phase      = spfd_pkg::PH_HUNT;
        sync_run   = '0;
        bytes_left = '0;
        xor_acc    = '0;
    endtask

    // Advance the deframer by one received byte; emitted marks a result item
    task automatic deframe_byte(input logic [spfd_pkg::BYTE_W-1:0] b, output bit emitted,
                                output spfd_pkg::t_result item);
        emitted = 1'b0;
        item    = '0;
        case (phase)
            spfd_pkg::PH_HUNT: begin
                if (b == sync_value) begin
                    if (sync_run < 5'd31)
                        sync_run = sync_run + 5'd1;
                    if (sync_run >= spfd_pkg::PREFIX_LEN) begin
                        phase    = spfd_pkg::PH_LEN_HI;
                        sync_run = '0;
                    end
                end else begin
                    sync_run = '0;
                end
            end
            spfd_pkg::PH_LEN_HI: begin
                len_high = b;
                phase    = spfd_pkg::PH_LEN_LO;
            end
            spfd_pkg::PH_LEN_LO: begin
                bytes_left = {len_high, b};
                xor_acc    = '0;
                if (bytes_left == '0)
                    restart_hunt();
                else
                    phase = spfd_pkg::PH_BODY;
            end
            default: begin
                emitted = 1'b1;
                if (bytes_left > 1) begin
                    xor_acc                 = xor_acc ^ b;
                    bytes_left              = bytes_left - 1'b1;
                    item.payload_byte       = b;
                    item.good_frame_count   = good_frames;
                end else begin
                    // Checksum byte: close the frame and go back to hunting
                    item.frame_end   = 1'b1;
                    item.checksum_ok = (xor_acc == b);
                    if (item.checksum_ok)
                        good_frames = good_frames + 1'b1;
                    item.good_frame_count = good_frames;
                    restart_hunt();
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_value  = spfd_pkg::SYNC_BYTE_RST;
            len_high    = '0;
            good_frames = '0;
            restart_hunt();
            frame_items_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_items_due.size() == 0) begin
                    report_mismatch("result item with none due", 32'(i_payload_byte), '0);
                end else begin
                    oldest = frame_items_due.pop_front();
                    if (i_payload_byte !== oldest.payload_byte)
                        report_mismatch("payload_byte", 32'(i_payload_byte),
                                        32'(oldest.payload_byte));
                    if (i_frame_end !== oldest.frame_end)
                        report_mismatch("frame_end", 32'(i_frame_end), 32'(oldest.frame_end));
                    if (i_checksum_ok !== oldest.checksum_ok)
                        report_mismatch("checksum_ok", 32'(i_checksum_ok),
                                        32'(oldest.checksum_ok));
                    if (i_good_frame_count !== oldest.good_frame_count)
                        report_mismatch("good_frame_count", i_good_frame_count,
                                        oldest.good_frame_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_rx_byte, produced, predicted);
                if (produced)
                    frame_items_due.push_back(predicted);
            end
            if (i_cfg_wr_en)
                sync_value = i_cfg_wr_data;
        end
        o_pending = frame_items_due.size();
    end

endmodule : deframer_checker

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top - testbench for the sync prefix frame deframer
// Feeds framed byte streams with bursty timing against a randomly stalling
// receiver, changes the sync byte between phases, and reports the verdict
// from the mismatch count of the checker running beside the block.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int BYTES_PER_PHASE = 190;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LIMIT_CYCLES    = 250000;

    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_TOGGLE = 3;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         rx_valid;
    logic                         rx_stall;
    logic [spfd_pkg::BYTE_W-1:0]  rx_byte;
    logic                         res_valid;
    logic                         res_stall;
    logic [spfd_pkg::BYTE_W-1:0]  res_payload;
    logic                         res_end;
    logic                         res_ok;
    logic [spfd_pkg::COUNT_W-1:0] res_count;
    logic                         cfg_wr_en;
    logic [spfd_pkg::BYTE_W-1:0]  cfg_wr_data;

    int mismatches;
    int items_due;
    int bytes_sent = 0;
    int burst_left = 8;
    bit hold_off_req;

    logic [spfd_pkg::BYTE_W-1:0] sync_now;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sync_prefix_frame_deframer i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (rx_valid),
        .o_stall            (rx_stall),
        .i_rx_byte          (rx_byte),
        .o_valid            (res_valid),
        .i_stall            (res_stall),
        .o_payload_byte     (res_payload),
        .o_frame_end        (res_end),
        .o_checksum_ok      (res_ok),
        .o_good_frame_count (res_count),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data)
    );

    deframer_checker i_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (rx_valid),
        .i_in_stall         (rx_stall),
        .i_rx_byte          (rx_byte),
        .i_out_valid        (res_valid),
        .i_out_stall        (res_stall),
        .i_payload_byte     (res_payload),
        .i_frame_end        (res_end),
        .i_checksum_ok      (res_ok),
        .i_good_frame_count (res_count),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_wr_data      (cfg_wr_data),
        .o_mismatches       (mismatches),
        .o_pending          (items_due)
    );

    // Offer one byte, hold it until accepted, then maybe leave a gap
    task automatic put_byte(input logic [spfd_pkg::BYTE_W-1:0] b);
        int gap;
        @(negedge clk);
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic send_prefix();
        repeat (spfd_pkg::PREFIX_LEN) put_byte(sync_now);
    endtask

    // Full frame with random payload; a bad checksum is flipped by a nonzero mask
    task automatic send_frame(input int len, input bit good_sum);
        logic [spfd_pkg::BYTE_W-1:0] sum;
        logic [spfd_pkg::BYTE_W-1:0] b;
        logic [spfd_pkg::LEN_W-1:0]  l;
        sum = '0;
        l   = spfd_pkg::LEN_W'(len);
        send_prefix();
        put_byte(l[15:8]);
        put_byte(l[7:0]);
        for (int i = 1; i < len; i++) begin
            b   = spfd_pkg::BYTE_W'($urandom_range(0, 255));
            sum = sum ^ b;
            put_byte(b);
        end
        if (len > 0)
            put_byte(good_sum ? sum : sum ^ spfd_pkg::BYTE_W'($urandom_range(1, 255)));
    endtask

    // Any byte except the current sync byte
    function automatic logic [spfd_pkg::BYTE_W-1:0] noise_byte();
        logic [spfd_pkg::BYTE_W-1:0] b;
        b = spfd_pkg::BYTE_W'($urandom_range(0, 255));
        return (b == sync_now) ? ~b : b;
    endfunction

    task automatic send_random_piece();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 8 && spfd_pkg::PREFIX_LEN > 1) begin
            // Broken prefix: too few sync bytes, then a stray byte
            repeat ($urandom_range(1, spfd_pkg::PREFIX_LEN - 1)) put_byte(sync_now);
            put_byte(noise_byte());
        end else if (sel < 15) begin
            repeat ($urandom_range(1, 4)) put_byte(noise_byte());
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                len = 0;
            else if (sel < 15)
                len = 1;
            else if (sel < 88)
                len = $urandom_range(2, 12);
            else
                len = $urandom_range(13, 48);
            send_frame(len, $urandom_range(0, 99) < 70);
        end
    endtask

    // Drain, let in-flight bytes settle, then write the sync byte
    task automatic write_sync(input logic [spfd_pkg::BYTE_W-1:0] value);
        @(negedge clk);
        rx_valid <= 1'b0;
        while (items_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sync_now     = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : receiver
        int seg;
        int mode;
        bit hold_done;
        hold_done = 1'b0;
        res_stall = 1'b0;
        wait (rst_n);
        forever begin
            if (hold_off_req && !hold_done) begin
                // Long hold-off so the block backs up into its input
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            seg  = $urandom_range(10, 100);
            mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
            repeat (seg) begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  res_stall <= 1'b0;
                    STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
                    default:     res_stall <= ~res_stall;
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [spfd_pkg::BYTE_W-1:0] phase_sync [NUM_PHASES];
        int target;
        rst_n        = 1'b0;
        rx_valid     = 1'b0;
        rx_byte      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_off_req = 1'b0;
        sync_now     = spfd_pkg::SYNC_BYTE_RST;
        phase_sync   = '{8'h00, 8'hFF, spfd_pkg::BYTE_W'($urandom_range(0, 255)),
                         spfd_pkg::BYTE_W'($urandom_range(0, 255)),
                         spfd_pkg::SYNC_BYTE_RST};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Stray byte, short run broken by a non-sync byte
        put_byte(8'h00);
        repeat (3) put_byte(sync_now);
        put_byte(8'h55);
        // Zero length is dropped
        send_prefix();
        put_byte(8'h00);
        put_byte(8'h00);
        // Length one: lone checksum against an empty payload
        send_prefix();
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h00);
        // Payload extremes with a wrong checksum
        send_prefix();
        put_byte(8'h00);
        put_byte(8'h03);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h0F);

        target = bytes_sent;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_sync(phase_sync[p]);
            if (p == 1)
                hold_off_req = 1'b1;
            target += BYTES_PER_PHASE;
            while (bytes_sent < target)
                send_random_piece();
        end

        @(negedge clk);
        rx_valid <= 1'b0;
        while (items_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("sync_prefix_frame_deframer verification clean");
        else
            $display("sync_prefix_frame_deframer verification failed");
        $finish;
    end

    initial begin : watchdog
        #(8 * LIMIT_CYCLES);
        $display("sync_prefix_frame_deframer verification failed");
        $finish;
    end

endmodule : tb_top
